// ----- rtl/gcd_pkg.sv -----
`timescale 1ns / 1ps

package gcd_pkg;

  localparam int LAT_W       = 31;
  localparam int LON_W       = 32;
  localparam int RADIUS_W    = 23;
  localparam int DIST_W      = 25;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 32;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;
  localparam logic [DIST_W-1:0]   DIST_MAX     = 25'd33554431;

  // Long division by shift and subtract, used only while elaborating constants.
  function automatic logic [63:0] divu(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      if (r >= b) begin
        r    = r - b;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 1/n in Q61 from its alternating series.
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] k;
    p   = divu(64'd1 << 61, n);
    sum = '0;
    k   = '0;
    while (p != 64'd0) begin
      t = divu(p, 2 * k + 64'd1);
      if (k[0]) begin
        sum = sum - t;
      end else begin
        sum = sum + t;
      end
      p = divu(divu(p, n), n);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] q61_to_q(input logic [63:0] v, input int f);
    return (v + (64'd1 << (60 - f))) >> (61 - f);
  endfunction

  function automatic logic [63:0] quarter_pi_q61();
    return 4 * atan_recip(64'd5) - atan_recip(64'd239);
  endfunction

  function automatic logic [63:0] atan_q(input int i, input int f);
    if (i == 0) begin
      return q61_to_q(quarter_pi_q61(), f);
    end
    return q61_to_q(atan_recip(64'd1 << i), f);
  endfunction

  function automatic logic [63:0] pi_q(input int f);
    return q61_to_q(4 * quarter_pi_q61(), f);
  endfunction

  function automatic logic [63:0] half_pi_q(input int f);
    return q61_to_q(2 * quarter_pi_q61(), f);
  endfunction

  // Squared inverse CORDIC gain, rounded to f fraction bits.
  function automatic logic [63:0] gain_sq_q(input int n, input int f);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] q;
    p = 64'd1 << 60;
    r = '0;
    q = '0;
    for (int i = 0; i < n; i++) begin
      if (2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    for (int i = 120; i >= 0; i--) begin
      r = (r << 1) | ((i == 120) ? 64'd1 : 64'd0);
      q = q << 1;
      if (r >= p) begin
        r = r - p;
        q = q | 64'd1;
      end
    end
    return (q + (64'd1 << (59 - f))) >> (60 - f);
  endfunction

  // Radians per 1e-7 degree, scaled by 2^(f+32) and rounded.
  function automatic logic [63:0] deg_scale_q(input int f);
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] bitv;
    r   = '0;
    q   = '0;
    d   = 64'd18000000000000000;
    num = 64'd31415926;
    for (int i = 24 + f + 32; i >= 0; i--) begin
      bitv = (i >= f + 32) ? ((num >> (i - f - 32)) & 64'd1) : 64'd0;
      r    = (r << 1) | bitv;
      q    = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    if (2 * r >= d) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

endpackage

// ----- rtl/gcd_rot.sv -----
`timescale 1ns / 1ps

module gcd_rot #(
  parameter int FRAC_BITS     = 30,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic signed [FRAC_BITS+3:0] in_z,
  output logic                        out_v,
  output logic signed [FRAC_BITS+3:0] out_x,
  output logic signed [FRAC_BITS+3:0] out_y
);

  localparam int AW = FRAC_BITS + 4;
  localparam int N  = CORDIC_STAGES;
  localparam logic signed [AW-1:0] PI      = AW'(gcd_pkg::pi_q(FRAC_BITS));
  localparam logic signed [AW-1:0] TWO_PI  = AW'(2 * gcd_pkg::pi_q(FRAC_BITS));
  localparam logic signed [AW-1:0] HALF_PI = AW'(gcd_pkg::half_pi_q(FRAC_BITS));
  localparam logic signed [AW-1:0] ONE     = AW'(64'd1 << FRAC_BITS);

  logic                 va_r;
  logic signed [AW-1:0] zw_r;
  logic                 v_r   [0:N];
  logic                 neg_r [0:N];
  logic signed [AW-1:0] x_r   [0:N];
  logic signed [AW-1:0] y_r   [0:N];
  logic signed [AW-1:0] z_r   [0:N];
  logic                 ov_r;
  logic signed [AW-1:0] ox_r;
  logic signed [AW-1:0] oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      va_r   <= in_v;
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_z > PI) begin
        zw_r <= in_z - TWO_PI;
      end else if (in_z < -PI) begin
        zw_r <= in_z + TWO_PI;
      end else begin
        zw_r <= in_z;
      end
      x_r[0] <= ONE;
      y_r[0] <= '0;
      if (zw_r > HALF_PI) begin
        z_r[0]   <= zw_r - PI;
        neg_r[0] <= 1'b1;
      end else if (zw_r < -HALF_PI) begin
        z_r[0]   <= zw_r + PI;
        neg_r[0] <= 1'b1;
      end else begin
        z_r[0]   <= zw_r;
        neg_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATN = AW'(gcd_pkg::atan_q(i - 1, FRAC_BITS));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i] <= neg_r[i-1];
        if (z_r[i-1] >= 0) begin
          x_r[i] <= x_r[i-1] - (y_r[i-1] >>> (i - 1));
          y_r[i] <= y_r[i-1] + (x_r[i-1] >>> (i - 1));
          z_r[i] <= z_r[i-1] - ATN;
        end else begin
          x_r[i] <= x_r[i-1] + (y_r[i-1] >>> (i - 1));
          y_r[i] <= y_r[i-1] - (x_r[i-1] >>> (i - 1));
          z_r[i] <= z_r[i-1] + ATN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= neg_r[N] ? -x_r[N] : x_r[N];
      oy_r <= neg_r[N] ? -y_r[N] : y_r[N];
    end
  end

  assign out_v = ov_r;
  assign out_x = ox_r;
  assign out_y = oy_r;

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (z_r[0] <= HALF_PI) && (z_r[0] >= -HALF_PI))
    else $error("Folded angle lies outside the half-pi range.");

endmodule

// ----- rtl/gcd_sqrt.sv -----
`timescale 1ns / 1ps

module gcd_sqrt #(
  parameter int FRAC_BITS = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [FRAC_BITS:0]   in_a,
  output logic                 out_v,
  output logic [FRAC_BITS:0]   out_root
);

  localparam int L  = FRAC_BITS + 1;
  localparam int DW = 2 * L;
  localparam int RW = FRAC_BITS + 4;

  logic          v_r    [0:L];
  logic [DW-1:0] val_r  [0:L];
  logic [RW-1:0] rem_r  [0:L];
  logic [L-1:0]  root_r [0:L];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r[0]  <= {1'b0, in_a, {FRAC_BITS{1'b0}}};
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= L; k++) begin : g_digit
    logic [RW-1:0] rem_t;
    logic [RW-1:0] trial;

    always_comb begin
      rem_t = {rem_r[k-1][RW-3:0], val_r[k-1][DW-1:DW-2]};
      trial = RW'({root_r[k-1], 2'b01});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k] <= val_r[k-1] << 2;
        if (rem_t >= trial) begin
          rem_r[k]  <= rem_t - trial;
          root_r[k] <= {root_r[k-1][L-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_t;
          root_r[k] <= {root_r[k-1][L-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v    = v_r[L];
  assign out_root = root_r[L];

endmodule

// ----- rtl/great_circle_distance_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_*      input      from_lat, from_lon, to_lat, to_lon (one point pair)
// out_*     output     distance_m
// cfg_*     input      sphere_radius_m
//
// One transfer is accepted per cycle when the output queue has room.
// A result passes through the two CORDIC pipelines and the digit-per-stage square root.
// A two-entry output queue absorbs a stall; the whole pipeline holds only once it is full.
// Reset is synchronous and clears valid bits, the queue and the radius (6371000 m).
module great_circle_distance_top #(
  parameter int FRAC_BITS     = 30,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // from_lat[30:0], from_lon[62:31], to_lat[93:63], to_lon[125:94], zero fill
  input  logic [gcd_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // distance_m[24:0], zero fill
  output logic [gcd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [gcd_pkg::RADIUS_W-1:0]       cfg_wr_data
);

  localparam int AW  = FRAC_BITS + 4;
  localparam int MW  = (AW > 34) ? AW : 34;
  localparam int N   = CORDIC_STAGES;
  localparam int PW  = gcd_pkg::RADIUS_W + AW - 1;
  localparam logic signed [MW-1:0] DEG = MW'(gcd_pkg::deg_scale_q(FRAC_BITS));
  localparam logic signed [MW-1:0] GSQ = MW'(gcd_pkg::gain_sq_q(N, FRAC_BITS));
  localparam logic signed [AW-1:0] ONE = AW'(64'd1 << FRAC_BITS);
  localparam logic [FRAC_BITS:0]   ONE_U = (FRAC_BITS + 1)'(64'd1 << FRAC_BITS);
  localparam logic [2*MW-1:0]      ONE_P = (2 * MW)'(1);
  localparam logic [PW-1:0]        HALF_D = PW'(64'd1 << (FRAC_BITS - 1));

  function automatic logic signed [AW-1:0] mulrnd(input logic signed [MW-1:0] a,
                                                  input logic signed [MW-1:0] b,
                                                  input int sh);
    logic [MW-1:0]   ma;
    logic [MW-1:0]   mb;
    logic [2*MW-1:0] p;
    logic [2*MW-1:0] r;
    ma = a[MW-1] ? MW'(-a) : MW'(a);
    mb = b[MW-1] ? MW'(-b) : MW'(b);
    p  = {{MW{1'b0}}, ma} * {{MW{1'b0}}, mb};
    r  = (p + (ONE_P << (sh - 1))) >> sh;
    return (a[MW-1] ^ b[MW-1]) ? -AW'(r) : AW'(r);
  endfunction

  logic signed [gcd_pkg::LAT_W-1:0] from_lat;
  logic signed [gcd_pkg::LON_W-1:0] from_lon;
  logic signed [gcd_pkg::LAT_W-1:0] to_lat;
  logic signed [gcd_pkg::LON_W-1:0] to_lon;

  logic                         en;
  logic [gcd_pkg::RADIUS_W-1:0] radius_r;

  logic                 s0_v_r;
  logic signed [MW-1:0] lat1_r, lat2_r, dlat_r, dlon_r;
  logic                 s1_v_r;
  logic signed [AW-1:0] z1_r, z2_r, zd_r, zl_r;

  logic                 rot_v;
  logic signed [AW-1:0] x1, y1, x2, y2, xd, yd, xl, yl;
  logic                 unused_rot_v [0:2];

  logic                 m1_v_r, m2_v_r, m3_v_r, m4_v_r;
  logic signed [AW-1:0] pyd_r, pyl_r, px_r;
  logic signed [AW-1:0] s1_r, s2_r, cc_r;
  logic signed [AW-1:0] t_r, s1b_r;
  logic signed [AW:0]   a_sum;
  logic [FRAC_BITS:0]   a_r, b_r;

  logic                 sq_v;
  logic                 sq_v_b;
  logic [FRAC_BITS:0]   sa, sb;

  logic                 vv_r [0:N];
  logic signed [AW-1:0] vx_r [0:N];
  logic signed [AW-1:0] vy_r [0:N];
  logic signed [AW-1:0] vz_r [0:N];

  logic                 ang_v_r;
  logic [AW-2:0]        ang_r;
  logic signed [AW:0]   ang2;
  logic                 prod_v_r;
  logic [PW-1:0]        prod_r;
  logic [PW-1:0]        dist_full;
  logic [gcd_pkg::DIST_W-1:0] dist_sat;

  logic [gcd_pkg::DIST_W-1:0] q_mem_r [0:1];
  logic                       wptr_r, rptr_r;
  logic [1:0]                 cnt_r;
  logic                       wr, rd;

  assign from_lat = in_tdata[30:0];
  assign from_lon = in_tdata[62:31];
  assign to_lat   = in_tdata[93:63];
  assign to_lon   = in_tdata[125:94];

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= MW'(from_lat);
      lat2_r <= MW'(to_lat);
      dlat_r <= MW'(to_lat) - MW'(from_lat);
      dlon_r <= MW'(to_lon) - MW'(from_lon);
      z1_r   <= mulrnd(lat1_r, DEG, 32);
      z2_r   <= mulrnd(lat2_r, DEG, 32);
      zd_r   <= mulrnd(dlat_r, DEG, 33);
      zl_r   <= mulrnd(dlon_r, DEG, 33);
    end
  end

  gcd_rot #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(N)) u_rot_lat1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(s1_v_r), .in_z(z1_r),
    .out_v(rot_v), .out_x(x1), .out_y(y1)
  );

  gcd_rot #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(N)) u_rot_lat2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(s1_v_r), .in_z(z2_r),
    .out_v(unused_rot_v[0]), .out_x(x2), .out_y(y2)
  );

  gcd_rot #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(N)) u_rot_dlat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(s1_v_r), .in_z(zd_r),
    .out_v(unused_rot_v[1]), .out_x(xd), .out_y(yd)
  );

  gcd_rot #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(N)) u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(s1_v_r), .in_z(zl_r),
    .out_v(unused_rot_v[2]), .out_x(xl), .out_y(yl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= rot_v;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
    end
  end

  always_comb begin
    a_sum = (AW + 1)'(s1b_r) + (AW + 1)'(t_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pyd_r <= mulrnd(MW'(yd), MW'(yd), FRAC_BITS);
      pyl_r <= mulrnd(MW'(yl), MW'(yl), FRAC_BITS);
      px_r  <= mulrnd(MW'(x1), MW'(x2), FRAC_BITS);
      s1_r  <= mulrnd(MW'(pyd_r), GSQ, FRAC_BITS);
      s2_r  <= mulrnd(MW'(pyl_r), GSQ, FRAC_BITS);
      cc_r  <= mulrnd(MW'(px_r), GSQ, FRAC_BITS);
      t_r   <= mulrnd(MW'(cc_r), MW'(s2_r), FRAC_BITS);
      s1b_r <= s1_r;
      if (a_sum < 0) begin
        a_r <= '0;
        b_r <= ONE_U;
      end else if (a_sum > (AW + 1)'(ONE)) begin
        a_r <= ONE_U;
        b_r <= '0;
      end else begin
        a_r <= a_sum[FRAC_BITS:0];
        b_r <= ONE_U - a_sum[FRAC_BITS:0];
      end
    end
  end

  gcd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(m4_v_r), .in_a(a_r),
    .out_v(sq_v), .out_root(sa)
  );

  gcd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(m4_v_r), .in_a(b_r),
    .out_v(sq_v_b), .out_root(sb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r[0] <= 1'b0;
    end else if (en) begin
      vv_r[0] <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= AW'(sb);
      vy_r[0] <= AW'(sa);
      vz_r[0] <= '0;
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_vec
    localparam logic signed [AW-1:0] ATN = AW'(gcd_pkg::atan_q(i - 1, FRAC_BITS));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vv_r[i] <= 1'b0;
      end else if (en) begin
        vv_r[i] <= vv_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (vy_r[i-1] > 0) begin
          vx_r[i] <= vx_r[i-1] + (vy_r[i-1] >>> (i - 1));
          vy_r[i] <= vy_r[i-1] - (vx_r[i-1] >>> (i - 1));
          vz_r[i] <= vz_r[i-1] + ATN;
        end else begin
          vx_r[i] <= vx_r[i-1] - (vy_r[i-1] >>> (i - 1));
          vy_r[i] <= vy_r[i-1] + (vx_r[i-1] >>> (i - 1));
          vz_r[i] <= vz_r[i-1] - ATN;
        end
      end
    end
  end

  always_comb begin
    ang2      = {vz_r[N], 1'b0};
    dist_full = (prod_r + HALF_D) >> FRAC_BITS;
    if (dist_full > PW'(gcd_pkg::DIST_MAX)) begin
      dist_sat = gcd_pkg::DIST_MAX;
    end else begin
      dist_sat = dist_full[gcd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_v_r  <= 1'b0;
      prod_v_r <= 1'b0;
    end else if (en) begin
      ang_v_r  <= vv_r[N];
      prod_v_r <= ang_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r  <= (ang2 < 0) ? '0 : ang2[AW-2:0];
      prod_r <= PW'(radius_r) * PW'(ang_r);
    end
  end

  assign wr = en & prod_v_r;
  assign rd = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_mem_r[wptr_r] <= dist_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr) begin
        wptr_r <= ~wptr_r;
      end
      if (rd) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {{(gcd_pkg::OUT_TDATA_W - gcd_pkg::DIST_W){1'b0}}, q_mem_r[rptr_r]};

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("Output queue count exceeds its depth.");

  a_sqrt_pair: assert property (@(posedge clk) disable iff (!rst_n)
    m4_v_r |-> ({1'b0, a_r} + {1'b0, b_r}) == {1'b0, ONE_U})
    else $error("Clamped a and its complement do not sum to one.");

  a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (rd && !wr) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("Output queue count did not drop after a transfer.");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_v == sq_v_b) && (unused_rot_v[0] == rot_v) && (unused_rot_v[1] == rot_v)
      && (unused_rot_v[2] == rot_v))
    else $error("Parallel lanes lost alignment.");

endmodule

// ----- dv/great_circle_distance_top_tb.sv -----
`timescale 1ns / 1ps

module great_circle_distance_top_tb;

  localparam int FB        = 30;
  localparam int NSTG      = 24;
  localparam int LIMIT_CYC = 400000;
  localparam int DRAIN_CYC = 200;

  localparam int LAT_W       = gcd_pkg::LAT_W;
  localparam int LON_W       = gcd_pkg::LON_W;
  localparam int RADIUS_W    = gcd_pkg::RADIUS_W;
  localparam int DIST_W      = gcd_pkg::DIST_W;
  localparam int IN_TDATA_W  = gcd_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = gcd_pkg::OUT_TDATA_W;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = gcd_pkg::RADIUS_RESET;
  localparam logic [DIST_W-1:0]   DIST_MAX     = gcd_pkg::DIST_MAX;

  class distance_scoreboard;
    longint atn[NSTG];
    longint pi_q;
    longint hpi_q;
    longint gsq;
    longint dscale;
    logic [RADIUS_W-1:0] radius;
    logic [DIST_W-1:0] pending[$];
    int errors;

    function new();
      longint unsigned qtr;
      logic [127:0] p;
      logic [127:0] num;
      logic [127:0] rem;
      logic [127:0] quo;
      qtr = 4 * series_atan(64'd5) - series_atan(64'd239);
      atn[0] = to_q(qtr);
      for (int i = 1; i < NSTG; i++) begin
        atn[i] = to_q(series_atan(64'd1 << i));
      end
      pi_q = to_q(4 * qtr);
      hpi_q = to_q(2 * qtr);
      p = 128'd1 << 60;
      for (int i = 0; i < NSTG; i++) begin
        if (2 * i < 64) begin
          p = p + (p >> (2 * i));
        end
      end
      quo = (128'd1 << 120) / p;
      gsq = longint'((quo + (128'd1 << (59 - FB))) >> (60 - FB));
      num = 128'd31415926 << (FB + 32);
      quo = num / 128'd18000000000000000;
      rem = num % 128'd18000000000000000;
      if (2 * rem >= 128'd18000000000000000) begin
        quo = quo + 1;
      end
      dscale = longint'(quo);
      radius = RADIUS_RESET;
      errors = 0;
    endfunction

    static function longint unsigned series_atan(longint unsigned n);
      longint unsigned p;
      longint unsigned acc;
      longint unsigned k;
      p = (64'd1 << 61) / n;
      acc = 0;
      k = 0;
      while (p != 0) begin
        if (k[0]) begin
          acc = acc - p / (2 * k + 1);
        end else begin
          acc = acc + p / (2 * k + 1);
        end
        p = p / n / n;
        k++;
      end
      return acc;
    endfunction

    static function longint to_q(longint unsigned v);
      return longint'((v + (64'd1 << (60 - FB))) >> (61 - FB));
    endfunction

    static function longint rmul(longint a, longint b, int sh);
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] pr;
      longint r;
      ma = (a < 0) ? 128'(-a) : 128'(a);
      mb = (b < 0) ? 128'(-b) : 128'(b);
      pr = (ma * mb + (128'd1 << (sh - 1))) >> sh;
      r = longint'({1'b0, pr[62:0]});
      return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function void rotate(longint z, output longint cx, output longint sy);
      longint x;
      longint y;
      longint t;
      bit flip;
      x = longint'(1) << FB;
      y = 0;
      flip = 0;
      while (z > pi_q) z -= 2 * pi_q;
      while (z < -pi_q) z += 2 * pi_q;
      if (z > hpi_q) begin
        z -= pi_q;
        flip = 1;
      end else if (z < -hpi_q) begin
        z += pi_q;
        flip = 1;
      end
      for (int i = 0; i < NSTG; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atn[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atn[i];
        end
        x = t;
      end
      cx = flip ? -x : x;
      sy = flip ? -y : y;
    endfunction

    function longint vector_angle(longint x, longint y);
      longint z;
      longint t;
      z = 0;
      for (int i = 0; i < NSTG; i++) begin
        if (y > 0) begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atn[i];
        end else begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atn[i];
        end
        x = t;
      end
      return z;
    endfunction

    static function longint root_scaled(longint unsigned v);
      longint unsigned w;
      longint unsigned root;
      longint unsigned rem;
      longint unsigned trial;
      w = v << FB;
      root = 0;
      rem = 0;
      for (int j = 31; j >= 0; j--) begin
        rem = (rem << 2) | ((w >> (2 * j)) & 3);
        trial = (root << 2) | 1;
        root = root << 1;
        if (rem >= trial) begin
          rem -= trial;
          root |= 1;
        end
      end
      return longint'(root);
    endfunction

    function void note_pair(logic [LAT_W-1:0] lat1, logic [LON_W-1:0] lon1,
                            logic [LAT_W-1:0] lat2, logic [LON_W-1:0] lon2);
      longint la1, lo1, la2, lo2;
      longint x1, y1, x2, y2, xd, yd, xl, yl, s1, s2, cc, a, ang, one;
      longint unsigned dist_m;
      one = longint'(1) << FB;
      la1 = longint'($signed(lat1));
      lo1 = longint'($signed(lon1));
      la2 = longint'($signed(lat2));
      lo2 = longint'($signed(lon2));
      rotate(rmul(la1, dscale, 32), x1, y1);
      rotate(rmul(la2, dscale, 32), x2, y2);
      rotate(rmul(la2 - la1, dscale, 33), xd, yd);
      rotate(rmul(lo2 - lo1, dscale, 33), xl, yl);
      s1 = rmul(rmul(yd, yd, FB), gsq, FB);
      s2 = rmul(rmul(yl, yl, FB), gsq, FB);
      cc = rmul(rmul(x1, x2, FB), gsq, FB);
      a = s1 + rmul(cc, s2, FB);
      if (a < 0) a = 0;
      if (a > one) a = one;
      ang = 2 * vector_angle(root_scaled(one - a), root_scaled(a));
      if (ang < 0) ang = 0;
      dist_m = (longint'(radius) * ang + (longint'(1) << (FB - 1))) >> FB;
      if (dist_m > DIST_MAX) dist_m = DIST_MAX;
      pending.push_back(dist_m[DIST_W-1:0]);
    endfunction

    function void check(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected distance transfer, actual %0d", $time, got);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          $display("%0t: distance_m mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en;
  logic [RADIUS_W-1:0] cfg_wr_data;

  distance_scoreboard sb = new();
  int send_idle;
  int recv_idle;
  int cycles;

  great_circle_distance_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_pair(in_tdata[30:0], in_tdata[62:31], in_tdata[93:63], in_tdata[125:94]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check(out_tdata[DIST_W-1:0]);
    end
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYC) begin
      $display("great_circle_distance_top test failed");
      $finish;
    end
  end

  task automatic send_pair(logic [LAT_W-1:0] lat1, logic [LON_W-1:0] lon1,
                           logic [LAT_W-1:0] lat2, logic [LON_W-1:0] lon2);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, lon2, lat2, lon1, lat1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle_and_write(logic [RADIUS_W-1:0] r);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    sb.radius = r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [LAT_W-1:0] rand_lat(bit raw);
    if (raw) return LAT_W'($urandom);
    return LAT_W'(longint'($urandom_range(1800000000)) - 900000000);
  endfunction

  function automatic logic [LON_W-1:0] rand_lon(bit raw);
    if (raw) return $urandom;
    return LON_W'(longint'($urandom_range(32'd3600000000)) - 1800000000);
  endfunction

  task automatic random_pairs(int count);
    logic [LAT_W-1:0] la1;
    logic [LON_W-1:0] lo1;
    bit raw;
    for (int n = 0; n < count; n++) begin
      raw = ($urandom_range(99) < 15);
      la1 = rand_lat(raw);
      lo1 = rand_lon(raw);
      if ($urandom_range(99) < 20) begin
        send_pair(la1, lo1, la1 + LAT_W'($urandom_range(2000) - 1000),
                  lo1 + LON_W'($urandom_range(2000) - 1000));
      end else begin
        send_pair(la1, lo1, rand_lat(raw), rand_lon(raw));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(LAT_W'(0), LON_W'(0), LAT_W'(0), LON_W'(0));
    send_pair(LAT_W'(123456789), LON_W'(-987654321), LAT_W'(123456789),
              LON_W'(-987654321));
    send_pair(LAT_W'(0), LON_W'(0), LAT_W'(0), LON_W'(1800000000));
    send_pair(LAT_W'(900000000), LON_W'(0), LAT_W'(-900000000), LON_W'(0));
    send_pair(LAT_W'(-900000000), LON_W'(-1800000000), LAT_W'(900000000),
              LON_W'(1800000000));
    send_pair(LAT_W'(0), LON_W'(-1800000000), LAT_W'(0), LON_W'(1800000000));
    send_pair(LAT_W'(900000000), LON_W'(1800000000), LAT_W'(900000000),
              LON_W'(-1800000000));
    send_pair(LAT_W'(0), LON_W'(0), LAT_W'(1), LON_W'(1));
    send_pair(LAT_W'(515000000), LON_W'(-1200000), LAT_W'(407000000),
              LON_W'(-740000000));
    send_pair(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000);
    send_pair('1, '1, '0, '0);
    send_pair(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF);
    send_pair(LAT_W'(0), LON_W'(0), LAT_W'(450000000), LON_W'(900000000));
    send_pair(LAT_W'(-450000000), LON_W'(1799999999), LAT_W'(450000000),
              LON_W'(-1799999999));

    wait_idle_and_write(RADIUS_W'(8388607));
    send_idle = 30;
    recv_idle = 46;
    random_pairs(500);

    wait_idle_and_write(RADIUS_W'(1));
    send_idle = 46;
    recv_idle = 30;
    random_pairs(500);

    wait_idle_and_write(RADIUS_W'($urandom_range(8388607, 1)));
    send_idle = 0;
    recv_idle = 0;
    random_pairs(400);

    wait_idle_and_write(RADIUS_W'(0));
    random_pairs(50);
    wait_idle_and_write(RADIUS_W'(6371000));
    random_pairs(50);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0) begin
      $display("great_circle_distance_top test passed");
    end else begin
      $display("great_circle_distance_top test failed");
    end
    $finish;
  end

endmodule
